FILE: hw/rtl/spi_master_fifo_controller_defines.svh
// Assertion macros for the SPI master FIFO controller.
`ifndef SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH
`define SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define SMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert an implication whose consequent is checked in the next cycle.
`define SMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/smfc_pkg.sv
// Package: constants and types of the SPI master FIFO controller.
package smfc_pkg;
    localparam int FifoDepth = 1024;
    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = PtrW + 1;
    localparam int RegWords = 31;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;
    localparam logic [1:0] OP_ILLEGAL = 2'd3;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_REJ   = 2'd2;

    localparam logic [4:0] W_GIE     = 5'd7;
    localparam logic [4:0] W_ISR     = 5'd8;
    localparam logic [4:0] W_SOFTRST = 5'd16;
    localparam logic [4:0] W_CTRL    = 5'd24;
    localparam logic [4:0] W_STAT    = 5'd25;
    localparam logic [4:0] W_TXDATA  = 5'd26;
    localparam logic [4:0] W_RXDATA  = 5'd27;
    localparam logic [4:0] W_SELECT  = 5'd28;
    localparam logic [4:0] W_NONE    = 5'd31;

    localparam logic [31:0] SOFTRST_KEY = 32'h0000_000a;
    localparam logic [31:0] EMPTY_READ  = 32'hdead_beef;
    localparam logic [31:0] CTRL_RESET  = 32'h0000_0180;
    localparam int CTRL_TXRST = 5;
    localparam int CTRL_RXRST = 6;
    localparam int CTRL_INHIBIT = 8;
    localparam logic [31:0] STAT_RESET = 32'h0000_0025;
    localparam int ST_TXFULL = 3;
    localparam int ST_TXEMPTY = 2;
    localparam int ST_RXFULL = 1;
    localparam int ST_RXEMPTY = 0;
    localparam int IS_RXNOTEMPTY = 8;
    localparam int IS_OVERRUN = 5;
    localparam int IS_RXFULL = 4;
    localparam int IS_TXEMPTY = 2;
endpackage

FILE: hw/rtl/smfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module smfc_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/spi_master_fifo_controller.sv
// Top level: SPI master register block with byte TX and RX FIFOs.
//
// Command-style block: a request is taken when i_start is high and o_busy is
// low, and each request gives exactly one result, shown for one cycle with
// o_done high; the receiver cannot stall it. A plain read or write passes
// through a decode step, then the result step; an RX data pop puts an RX
// RAM read in between. A write that lets the TX FIFO drain, or a slave
// reply, adds an empty check, and for each byte moved when no slave is
// selected a TX RAM read, then an RX push; with slave 0 selected it stops
// on the first byte and returns a shift request. The byte FIFOs live in
// two RAMs with registered reads; the 31-word register file is held in
// flops since only seven words carry behavior. Queue contents are never
// cleared: only pushed entries are read. Kinds: 0 done, 1 shift byte
// request, 2 rejected.
`include "spi_master_fifo_controller_defines.svh"
module spi_master_fifo_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [6:0]  i_byte_offset,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_slave_byte,
    output logic        o_done,
    output logic [1:0]  o_kind,
    output logic [31:0] o_read_data,
    output logic [7:0]  o_tx_byte,
    output logic        o_slave_select_n
);
    localparam int PW = smfc_pkg::PtrW;
    localparam int CW = smfc_pkg::CntW;
    localparam logic [CW-1:0] DEPTH = CW'(smfc_pkg::FifoDepth);

    typedef enum logic [2:0] {
        S_IDLE, S_RXRD, S_DRAIN, S_TXRD, S_FIN
    } t_state;

    t_state r_state;
    logic [31:0] r_regs [smfc_pkg::RegWords];
    logic [PW-1:0] r_tx_head, r_rx_head;
    logic [CW-1:0] r_tx_cnt, r_rx_cnt;
    logic r_pend;
    logic [1:0] r_kind;
    logic [31:0] r_rd;
    logic [7:0] r_txb;

    // RAM ports
    logic tx_we, rx_we;
    logic [PW-1:0] tx_waddr, rx_waddr, tx_raddr, rx_raddr;
    logic [7:0] tx_wdata, rx_wdata, tx_rdata, rx_rdata;

    smfc_ram #(.Width(8), .Depth(smfc_pkg::FifoDepth)) u_tx_ram (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(tx_wdata),
        .i_raddr(tx_raddr), .o_rdata(tx_rdata));
    smfc_ram #(.Width(8), .Depth(smfc_pkg::FifoDepth)) u_rx_ram (
        .i_clk(i_clk), .i_we(rx_we), .i_waddr(rx_waddr), .i_wdata(rx_wdata),
        .i_raddr(rx_raddr), .o_rdata(rx_rdata));

    logic accept;
    logic [4:0] word;
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign word = i_byte_offset[6:2];

    logic [31:0] isr, ctrl, sel;
    assign isr  = r_regs[smfc_pkg::W_ISR];
    assign ctrl = r_regs[smfc_pkg::W_CTRL];
    assign sel  = r_regs[smfc_pkg::W_SELECT];

    // TX push on an accepted TXDATA write; RX push when a byte is received (reply or drain)
    assign tx_we = accept && (i_opcode == smfc_pkg::OP_WRITE) && !r_pend
                   && (word == smfc_pkg::W_TXDATA) && (r_tx_cnt < DEPTH);
    assign tx_waddr = r_tx_head + r_tx_cnt[PW-1:0];
    assign tx_wdata = i_write_data[7:0];
    assign tx_raddr = r_tx_head;
    assign rx_raddr = r_rx_head;
    assign rx_waddr = r_rx_head + r_rx_cnt[PW-1:0];

    logic rcv_reply, rcv_drain;
    assign rcv_reply = accept && (i_opcode == smfc_pkg::OP_REPLY) && r_pend;
    assign rcv_drain = (r_state == S_TXRD) && !(sel[0] == 1'b0);
    assign rx_we = (rcv_reply || rcv_drain) && (r_rx_cnt < DEPTH);
    assign rx_wdata = rcv_reply ? i_slave_byte : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < smfc_pkg::RegWords; k++) begin
                r_regs[k] <= '0;
            end
            r_regs[smfc_pkg::W_CTRL] <= smfc_pkg::CTRL_RESET;
            r_regs[smfc_pkg::W_STAT] <= smfc_pkg::STAT_RESET;
            r_regs[smfc_pkg::W_SELECT] <= '1;
            r_tx_head <= '0; r_tx_cnt <= '0;
            r_rx_head <= '0; r_rx_cnt <= '0;
            r_pend <= 1'b0;
            o_done <= 1'b0;
            r_kind <= smfc_pkg::KIND_DONE;
            r_rd <= '0; r_txb <= '0;
        end else begin
            o_done <= 1'b0;
            // byte reception shared by reply and zero-fill drain
            if (rcv_reply || rcv_drain) begin
                if (r_rx_cnt >= DEPTH) begin
                    r_regs[smfc_pkg::W_ISR][smfc_pkg::IS_OVERRUN] <= 1'b1;
                end else begin
                    r_rx_cnt <= r_rx_cnt + 1'b1;
                    if (r_rx_cnt + 1'b1 >= DEPTH) begin
                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXFULL] <= 1'b1;
                        r_regs[smfc_pkg::W_ISR][smfc_pkg::IS_RXFULL] <= 1'b1;
                    end
                end
                r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXEMPTY] <= 1'b0;
                r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXFULL] <= 1'b0;
                r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXEMPTY] <= 1'b1;
                r_regs[smfc_pkg::W_ISR][smfc_pkg::IS_TXEMPTY] <= 1'b1;
                r_regs[smfc_pkg::W_ISR][smfc_pkg::IS_RXNOTEMPTY] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= smfc_pkg::KIND_DONE;
                        r_rd <= '0;
                        r_txb <= '0;
                        r_state <= S_FIN;
                        if (i_opcode == smfc_pkg::OP_ILLEGAL
                            || ((i_opcode == smfc_pkg::OP_REPLY) != r_pend)) begin
                            r_kind <= smfc_pkg::KIND_REJ;
                        end else if (i_opcode == smfc_pkg::OP_REPLY) begin
                            r_pend <= 1'b0;
                            r_state <= S_DRAIN;
                        end else if (i_opcode == smfc_pkg::OP_READ) begin
                            if (word == smfc_pkg::W_RXDATA) begin
                                if (r_rx_cnt == '0) begin
                                    r_rd <= smfc_pkg::EMPTY_READ;
                                end else begin
                                    r_state <= S_RXRD;
                                    r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXFULL] <= 1'b0;
                                    r_rx_head <= r_rx_head + 1'b1;
                                    r_rx_cnt <= r_rx_cnt - 1'b1;
                                    if (r_rx_cnt == CW'(1)) begin
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXEMPTY]
                                            <= 1'b1;
                                    end
                                end
                            end else if (word != smfc_pkg::W_NONE) begin
                                r_rd <= r_regs[word];
                            end
                        end else begin
                            priority case (word)
                                smfc_pkg::W_SOFTRST: begin
                                    if (i_write_data == smfc_pkg::SOFTRST_KEY) begin
                                        for (int k = 0; k < smfc_pkg::RegWords; k++) begin
                                            r_regs[k] <= '0;
                                        end
                                        r_regs[smfc_pkg::W_CTRL] <= smfc_pkg::CTRL_RESET;
                                        r_regs[smfc_pkg::W_STAT] <= smfc_pkg::STAT_RESET;
                                        r_regs[smfc_pkg::W_SELECT] <= '1;
                                        r_tx_head <= '0; r_tx_cnt <= '0;
                                        r_rx_head <= '0; r_rx_cnt <= '0;
                                    end
                                end
                                smfc_pkg::W_TXDATA: begin
                                    r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXEMPTY] <= 1'b0;
                                    if (r_tx_cnt < DEPTH) begin
                                        r_tx_cnt <= r_tx_cnt + 1'b1;
                                    end
                                    if (r_tx_cnt >= DEPTH - 1'b1) begin
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXFULL] <= 1'b1;
                                    end
                                    if (!ctrl[smfc_pkg::CTRL_INHIBIT]) begin
                                        r_state <= S_DRAIN;
                                    end
                                end
                                smfc_pkg::W_STAT, smfc_pkg::W_NONE: ;
                                smfc_pkg::W_ISR: r_regs[smfc_pkg::W_ISR] <= isr ^ i_write_data;
                                smfc_pkg::W_CTRL: begin
                                    if (i_write_data[smfc_pkg::CTRL_RXRST]) begin
                                        r_rx_head <= '0; r_rx_cnt <= '0;
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXEMPTY] <= 1'b1;
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_RXFULL] <= 1'b0;
                                    end
                                    if (i_write_data[smfc_pkg::CTRL_TXRST]) begin
                                        r_tx_head <= '0; r_tx_cnt <= '0;
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXFULL] <= 1'b0;
                                        r_regs[smfc_pkg::W_STAT][smfc_pkg::ST_TXEMPTY] <= 1'b1;
                                    end
                                    r_regs[smfc_pkg::W_CTRL] <= i_write_data & ~32'h60;
                                    if (!i_write_data[smfc_pkg::CTRL_INHIBIT]) begin
                                        r_state <= S_DRAIN;
                                    end
                                end
                                default: r_regs[word] <= i_write_data;
                            endcase
                        end
                    end
                end
                S_RXRD: begin
                    // rx_rdata holds the byte at the old head this cycle
                    r_rd <= {24'd0, rx_rdata};
                    r_state <= S_FIN;
                end
                S_DRAIN: begin
                    // TX RAM read issued at r_tx_head this cycle
                    if (r_tx_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_tx_head <= r_tx_head + 1'b1;
                        r_tx_cnt <= r_tx_cnt - 1'b1;
                        r_state <= S_TXRD;
                    end
                end
                S_TXRD: begin
                    if (!sel[0]) begin
                        r_pend <= 1'b1;
                        r_kind <= smfc_pkg::KIND_SHIFT;
                        r_txb <= tx_rdata;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_FIN: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_kind = r_kind;
    assign o_read_data = r_rd;
    assign o_tx_byte = r_txb;
    assign o_slave_select_n = sel[0];

    `SMF_ASSERT_IMP(a_cnt_tx, i_clk, i_rst_n, 1'b1, r_tx_cnt <= DEPTH)
    `SMF_ASSERT_IMP(a_cnt_rx, i_clk, i_rst_n, 1'b1, r_rx_cnt <= DEPTH)
    `SMF_ASSERT_NEXT(a_done_one, i_clk, i_rst_n, o_done, !o_done)
    `SMF_ASSERT_IMP(a_shift_pend, i_clk, i_rst_n,
        o_done && o_kind == smfc_pkg::KIND_SHIFT, r_pend)
endmodule
